// ===== design/tfd_pkg.sv =====
// types, constants and posture codes shared by the tilt fall detector
package tfd_pkg;

  localparam int WINDOW_DEPTH  = 16;
  localparam int SAMPLE_BITS   = 16;
  localparam int SUM_BITS      = SAMPLE_BITS + $clog2(WINDOW_DEPTH);
  localparam int COUNT_BITS    = $clog2(WINDOW_DEPTH + 1);
  localparam int SQ_BITS       = 2 * SUM_BITS;
  localparam int R3_BITS       = SQ_BITS + 2;
  localparam int IN_DATA_BITS  = ((3 * SAMPLE_BITS + 1 + 7) / 8) * 8;
  localparam int OUT_DATA_BITS = 8;

  typedef enum logic [2:0] {
    POSTURE_UNKNOWN       = 3'd0,
    POSTURE_FALLING_FRONT = 3'd1,
    POSTURE_FALL_FRONT    = 3'd2,
    POSTURE_FALLING_BACK  = 3'd3,
    POSTURE_FALL_BACK     = 3'd4,
    POSTURE_SIT           = 3'd5
  } posture_e;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] x;
    logic signed [SAMPLE_BITS-1:0] y;
    logic signed [SAMPLE_BITS-1:0] z;
  } sample_t;

  typedef struct packed {
    logic signed [SUM_BITS-1:0] x;
    logic signed [SUM_BITS-1:0] y;
    logic signed [SUM_BITS-1:0] z;
  } sums_t;

  typedef struct packed {
    logic b_load;
    logic c_load;
  } ctrl_t;

endpackage

// ===== design/tfd_cell.sv =====
// one window cell holding a three-axis sample, shifted to its neighbor on each new word
module tfd_cell (
  input  logic           clk_i,
  input  logic           shift_i,
  input  tfd_pkg::sample_t sample_i,
  output tfd_pkg::sample_t sample_o
);
  import tfd_pkg::*;

  sample_t sample_q;

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      sample_q <= sample_i;
    end
  end

  assign sample_o = sample_q;

endmodule

// ===== design/tfd_window.sv =====
// sliding window as a chain of cells with running axis sums and fill count
module tfd_window (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  tfd_pkg::sample_t sample_i,
  output tfd_pkg::sums_t   sums_o,
  output logic             full_o
);
  import tfd_pkg::*;

  sample_t                chain [WINDOW_DEPTH+1];
  sums_t                  sums_q, sums_d;
  logic [COUNT_BITS-1:0]  fill_count_q, fill_count_d;
  logic                   full;

  assign chain[0] = sample_i;

  for (genvar i = 0; i < WINDOW_DEPTH; i++) begin : g_cell
    tfd_cell u_cell (
      .clk_i    (clk_i),
      .shift_i  (accept_i),
      .sample_i (chain[i]),
      .sample_o (chain[i+1])
    );
  end

  assign full = (fill_count_q == COUNT_BITS'(WINDOW_DEPTH));

  always_comb begin
    sums_d       = sums_q;
    fill_count_d = fill_count_q;
    if (accept_i) begin
      sums_d.x = sums_q.x + SUM_BITS'(sample_i.x);
      sums_d.y = sums_q.y + SUM_BITS'(sample_i.y);
      sums_d.z = sums_q.z + SUM_BITS'(sample_i.z);
      if (full) begin
        // oldest sample leaves the window
        sums_d.x = sums_d.x - SUM_BITS'(chain[WINDOW_DEPTH].x);
        sums_d.y = sums_d.y - SUM_BITS'(chain[WINDOW_DEPTH].y);
        sums_d.z = sums_d.z - SUM_BITS'(chain[WINDOW_DEPTH].z);
      end else begin
        fill_count_d = fill_count_q + COUNT_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sums_q       <= '0;
      fill_count_q <= '0;
    end else begin
      sums_q       <= sums_d;
      fill_count_q <= fill_count_d;
    end
  end

  assign sums_o = sums_q;
  assign full_o = full;

endmodule

// ===== design/tfd_classify.sv =====
// squared tilt compares and posture classification with held state
module tfd_classify (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tfd_pkg::ctrl_t      ctrl_i,
  input  tfd_pkg::sums_t      sums_i,
  input  logic                feet_i,
  input  logic                full_i,
  output logic                fallen_o,
  output tfd_pkg::posture_e   posture_o,
  output logic                full_o
);
  import tfd_pkg::*;

  logic signed [SQ_BITS-1:0] prod_x, prod_y, prod_z;
  logic [SQ_BITS-2:0]        x2_q;
  logic [SQ_BITS-1:0]        r2_q;
  logic                      x_neg_q, feet_b_q, full_b_q;
  logic [R3_BITS-1:0]        r2x3;
  logic                      above45, above60;
  posture_e                  posture_q, posture_d;
  logic                      fallen_q, fallen_d, full_c_q;

  assign prod_x = sums_i.x * sums_i.x;
  assign prod_y = sums_i.y * sums_i.y;
  assign prod_z = sums_i.z * sums_i.z;

  // squares are nonnegative
  always_ff @(posedge clk_i) begin
    if (ctrl_i.b_load) begin
      x2_q     <= prod_x[SQ_BITS-2:0];
      r2_q     <= {1'b0, prod_y[SQ_BITS-2:0]} + {1'b0, prod_z[SQ_BITS-2:0]};
      x_neg_q  <= sums_i.x[SUM_BITS-1];
      feet_b_q <= feet_i;
      full_b_q <= full_i;
    end
  end

  assign r2x3    = {1'b0, r2_q, 1'b0} + {2'b00, r2_q};
  assign above45 = {1'b0, x2_q} > r2_q;
  assign above60 = {3'b000, x2_q} > r2x3;

  always_comb begin
    posture_d = posture_q;
    fallen_d  = fallen_q;
    if (!full_b_q || !feet_b_q) begin
      fallen_d = 1'b0;
    end else if (above45 && !x_neg_q) begin
      if (above60) begin
        posture_d = POSTURE_FALL_FRONT;
        fallen_d  = 1'b1;
      end else begin
        posture_d = POSTURE_FALLING_FRONT;
      end
    end else if (above45 && x_neg_q) begin
      if (above60) begin
        posture_d = POSTURE_FALL_BACK;
        fallen_d  = 1'b1;
      end else begin
        posture_d = POSTURE_FALLING_BACK;
      end
    end else begin
      posture_d = POSTURE_SIT;
      fallen_d  = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      posture_q <= POSTURE_UNKNOWN;
      fallen_q  <= 1'b0;
      full_c_q  <= 1'b0;
    end else if (ctrl_i.c_load) begin
      posture_q <= posture_d;
      fallen_q  <= fallen_d;
      full_c_q  <= full_b_q;
    end
  end

  assign fallen_o  = fallen_q;
  assign posture_o = posture_q;
  assign full_o    = full_c_q;

endmodule

// ===== design/tilt_fall_detector.sv =====
// top level of the tilt fall detector: stream ports and pipeline handshake
//
// Each word carries one signed three-axis torso acceleration sample and a
// feet-off-ground flag; each word yields one result word with fallen, posture
// and window-full. One word is taken per clock while the pipeline is not held
// by output back-pressure. Accepting a sample shifts it into the chain of
// sixteen window cells and updates the running sums; stage b then registers
// the squares of the sums, and stage c does the 45 and 60 degree compares,
// loads the held posture and offers the result word. Each stage has its own
// valid bit, so up to two more words are taken while a finished result waits
// at the output. Until sixteen samples are held, or while a foot is on the
// ground, fallen reads zero and the last posture is kept.
module tilt_fall_detector (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // accel_x, accel_y, accel_z, feet_off_ground, zero fill
  input  logic [tfd_pkg::IN_DATA_BITS-1:0]    s_axis_tdata,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // fallen, posture, window_full, zero fill
  output logic [tfd_pkg::OUT_DATA_BITS-1:0]   m_axis_tdata
);
  import tfd_pkg::*;

  localparam int FEET_BIT = 3 * SAMPLE_BITS;

  logic     a_valid_q, b_valid_q, m_valid_q;
  logic     feet_a_q;
  logic     accept;
  ctrl_t    ctrl;
  sample_t  sample;
  sums_t    sums;
  logic     win_full;
  logic     fallen, full_out;
  posture_e posture;

  assign ctrl.c_load  = b_valid_q && (!m_valid_q || m_axis_tready);
  assign ctrl.b_load  = a_valid_q && (!b_valid_q || ctrl.c_load);
  assign s_axis_tready = !a_valid_q || ctrl.b_load;
  assign accept       = s_axis_tvalid && s_axis_tready;

  assign sample.x = s_axis_tdata[SAMPLE_BITS-1:0];
  assign sample.y = s_axis_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
  assign sample.z = s_axis_tdata[3*SAMPLE_BITS-1:2*SAMPLE_BITS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      if (accept || ctrl.b_load) begin
        a_valid_q <= accept;
      end
      if (ctrl.b_load || ctrl.c_load) begin
        b_valid_q <= ctrl.b_load;
      end
      if (ctrl.c_load || m_axis_tready) begin
        m_valid_q <= ctrl.c_load;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      feet_a_q <= s_axis_tdata[FEET_BIT];
    end
  end

  tfd_window u_window (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .sample_i (sample),
    .sums_o   (sums),
    .full_o   (win_full)
  );

  tfd_classify u_classify (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (ctrl),
    .sums_i    (sums),
    .feet_i    (feet_a_q),
    .full_i    (win_full),
    .fallen_o  (fallen),
    .posture_o (posture),
    .full_o    (full_out)
  );

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {(OUT_DATA_BITS-5)'(0), full_out, posture, fallen};

endmodule

// ===== sim/tilt_fall_detector_tb.sv =====
// testbench for the tilt fall detector: stream driver, bit-true posture predictor, result checker
module tilt_fall_detector_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tfd_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int QUIET_START = 300;
  localparam int QUIET_END   = 700;
  localparam int RANDOM_WORDS = 1100;

  typedef struct packed {
    logic     fallen;
    posture_e posture;
    logic     window_full;
  } fall_verdict_t;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     s_axis_tvalid = 1'b0;
  logic                     s_axis_tready;
  // accel_x, accel_y, accel_z, feet_off_ground, zero fill
  logic [IN_DATA_BITS-1:0]  s_axis_tdata = '0;
  logic                     m_axis_tvalid;
  logic                     m_axis_tready = 1'b0;
  // fallen, posture, window_full, zero fill
  logic [OUT_DATA_BITS-1:0] m_axis_tdata;

  logic [IN_DATA_BITS-1:0] pending_words[$];
  fall_verdict_t           expected_verdicts[$];

  logic signed [SAMPLE_BITS-1:0] ring_x[WINDOW_DEPTH];
  logic signed [SAMPLE_BITS-1:0] ring_y[WINDOW_DEPTH];
  logic signed [SAMPLE_BITS-1:0] ring_z[WINDOW_DEPTH];
  longint   run_x = 0;
  longint   run_y = 0;
  longint   run_z = 0;
  int       held_count = 0;
  int       ring_pos = 0;
  posture_e last_posture = POSTURE_UNKNOWN;
  logic     last_fallen = 1'b0;

  int run_cycles = 0;
  int samples_taken = 0;
  int verdicts_checked = 0;
  int mismatches = 0;
  int posture_hits[6] = '{default: 0};

  tilt_fall_detector i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  function bit take_gap();
    return !(run_cycles >= QUIET_START && run_cycles < QUIET_END) &&
           ($urandom_range(99) < 11);
  endfunction

  function void queue_sample(input int ax, input int ay, input int az, input bit off_ground);
    pending_words.insert(pending_words.size(),
                         {7'b0, off_ground, SAMPLE_BITS'(az), SAMPLE_BITS'(ay),
                          SAMPLE_BITS'(ax)});
  endfunction

  // slide the window, update the sums, classify the forward or backward tilt and queue the expected verdict
  function void track_sample(input logic [IN_DATA_BITS-1:0] word);
    logic signed [SAMPLE_BITS-1:0] ax;
    logic signed [SAMPLE_BITS-1:0] ay;
    logic signed [SAMPLE_BITS-1:0] az;
    logic          off_ground;
    logic          full;
    longint        x2;
    longint        r2;
    fall_verdict_t verdict;
    ax = word[SAMPLE_BITS-1:0];
    ay = word[2*SAMPLE_BITS-1:SAMPLE_BITS];
    az = word[3*SAMPLE_BITS-1:2*SAMPLE_BITS];
    off_ground = word[3*SAMPLE_BITS];
    if (held_count == WINDOW_DEPTH) begin
      run_x -= longint'(ring_x[ring_pos]);
      run_y -= longint'(ring_y[ring_pos]);
      run_z -= longint'(ring_z[ring_pos]);
    end else begin
      held_count++;
    end
    ring_x[ring_pos] = ax;
    ring_y[ring_pos] = ay;
    ring_z[ring_pos] = az;
    run_x += longint'(ax);
    run_y += longint'(ay);
    run_z += longint'(az);
    ring_pos = (ring_pos + 1) % WINDOW_DEPTH;
    full = (held_count == WINDOW_DEPTH);
    if (!full || !off_ground) begin
      last_fallen = 1'b0;
    end else begin
      x2 = run_x * run_x;
      r2 = run_y * run_y + run_z * run_z;
      // exactly 45 or 60 degrees is not above the threshold
      if (x2 > r2 && run_x > 0) begin
        if (x2 > 3 * r2) begin
          last_posture = POSTURE_FALL_FRONT;
          last_fallen = 1'b1;
        end else begin
          last_posture = POSTURE_FALLING_FRONT;
        end
      end else if (x2 > r2 && run_x < 0) begin
        if (x2 > 3 * r2) begin
          last_posture = POSTURE_FALL_BACK;
          last_fallen = 1'b1;
        end else begin
          last_posture = POSTURE_FALLING_BACK;
        end
      end else begin
        last_posture = POSTURE_SIT;
        last_fallen = 1'b1;
      end
    end
    verdict.fallen = last_fallen;
    verdict.posture = last_posture;
    verdict.window_full = full;
    expected_verdicts.insert(expected_verdicts.size(), verdict);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata <= '0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        track_sample(s_axis_tdata);
        samples_taken++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_words.size() != 0 && !take_gap()) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= pending_words.pop_front();
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin : result_check
    fall_verdict_t want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= !take_gap();
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_verdicts.size() == 0) begin
          $error("result word with no sample pending: %h", m_axis_tdata);
          mismatches++;
        end else begin
          want = expected_verdicts.pop_front();
          verdicts_checked++;
          if (want.window_full) begin
            posture_hits[want.posture]++;
          end
          if (m_axis_tdata[0] !== want.fallen) begin
            $error("fallen: expected %0d, got %0d", want.fallen, m_axis_tdata[0]);
            mismatches++;
          end
          if (m_axis_tdata[3:1] !== want.posture) begin
            $error("posture: expected %0d, got %0d", want.posture, m_axis_tdata[3:1]);
            mismatches++;
          end
          if (m_axis_tdata[4] !== want.window_full) begin
            $error("window_full: expected %0d, got %0d", want.window_full, m_axis_tdata[4]);
            mismatches++;
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      run_cycles++;
      if (run_cycles > CYCLE_LIMIT) begin
        $display("FAIL tilt_fall_detector");
        $finish;
      end
    end
  end

  initial begin
    int tilt_sign;
    int pick;
    int ax;
    int ay;
    int az;

    // window fill with extremes, then all sums zero
    queue_sample(32767, -32768, 32767, 1'b0);
    queue_sample(-32768, 32767, -32768, 1'b1);
    for (int k = 0; k < 13; k++) begin
      queue_sample(0, 0, 0, k[0]);
    end
    queue_sample(1, 1, 1, 1'b1);
    queue_sample(0, 0, 0, 1'b1);
    // foot on ground holds the posture
    queue_sample(0, 0, 0, 1'b0);
    // falling front, fall front, fall back, falling back with held fallen flag
    queue_sample(5, 4, 0, 1'b1);
    queue_sample(30, -1, -1, 1'b1);
    queue_sample(-100, -4, 0, 1'b1);
    queue_sample(0, 32, 48, 1'b1);
    queue_sample(128, -32, -48, 1'b1);
    // exactly 45 degrees
    queue_sample(0, 64, 0, 1'b1);
    queue_sample(0, 0, 0, 1'b0);

    tilt_sign = 1;
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if ($urandom_range(39) == 0) begin
        tilt_sign = -tilt_sign;
      end
      pick = $urandom_range(99);
      if (pick < 40) begin
        ax = $urandom_range(65535) - 32768;
        ay = $urandom_range(65535) - 32768;
        az = $urandom_range(65535) - 32768;
      end else if (pick < 70) begin
        ax = (tilt_sign > 0) ? $urandom_range(32767, 6000) : -$urandom_range(32768, 6000);
        ay = $urandom_range(8000) - 4000;
        az = $urandom_range(8000) - 4000;
      end else if (pick < 90) begin
        ax = $urandom_range(16) - 8;
        ay = $urandom_range(16) - 8;
        az = $urandom_range(16) - 8;
      end else begin
        ax = ($urandom_range(1) != 0) ? 32767 : -32768;
        ay = ($urandom_range(1) != 0) ? -1 : 0;
        az = ($urandom_range(1) != 0) ? -32768 : 1;
      end
      queue_sample(ax, ay, az, $urandom_range(99) < 80);
    end

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_words.size() != 0 || s_axis_tvalid || expected_verdicts.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (8) @(posedge clk_i);

    $display("%0d samples sent, %0d result words checked, %0d mismatches",
             samples_taken, verdicts_checked, mismatches);
    $write("full-window postures: sit %0d, falling front %0d, fall front %0d, ",
           posture_hits[POSTURE_SIT], posture_hits[POSTURE_FALLING_FRONT],
           posture_hits[POSTURE_FALL_FRONT]);
    $display("falling back %0d, fall back %0d",
             posture_hits[POSTURE_FALLING_BACK], posture_hits[POSTURE_FALL_BACK]);
    if (mismatches == 0) begin
      $display("PASS tilt_fall_detector");
    end else begin
      $display("FAIL tilt_fall_detector");
    end
    $finish;
  end

endmodule
